// File: hdl/stack_bytecode_machine_core_assert.svh
// Assertion macros for the stack bytecode machine core
`ifndef STACK_BYTECODE_MACHINE_CORE_ASSERT_SVH
`define STACK_BYTECODE_MACHINE_CORE_ASSERT_SVH

`ifndef SYNTH
`define SBM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("sbm assertion failed");
`define SBM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("sbm assertion failed");
`else
`define SBM_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define SBM_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: hdl/sbm_pkg.sv
`default_nettype none
package sbm_pkg;

	localparam logic [7:0] OP_HALT     = 8'h00;
	localparam logic [7:0] OP_PUSH8    = 8'h01;
	localparam logic [7:0] OP_PUSH16   = 8'h02;
	localparam logic [7:0] OP_POP      = 8'h03;
	localparam logic [7:0] OP_DUP      = 8'h04;
	localparam logic [7:0] OP_SWAP     = 8'h05;
	localparam logic [7:0] OP_ADD      = 8'h10;
	localparam logic [7:0] OP_SUB      = 8'h11;
	localparam logic [7:0] OP_MUL      = 8'h12;
	localparam logic [7:0] OP_MOD      = 8'h13;
	localparam logic [7:0] OP_XOR      = 8'h14;
	localparam logic [7:0] OP_AND      = 8'h15;
	localparam logic [7:0] OP_OR       = 8'h16;
	localparam logic [7:0] OP_NOT      = 8'h17;
	localparam logic [7:0] OP_ROL      = 8'h18;
	localparam logic [7:0] OP_ROR      = 8'h19;
	localparam logic [7:0] OP_LOAD     = 8'h20;
	localparam logic [7:0] OP_STORE    = 8'h21;
	localparam logic [7:0] OP_LDI      = 8'h22;
	localparam logic [7:0] OP_JMP      = 8'h30;
	localparam logic [7:0] OP_JZ       = 8'h31;
	localparam logic [7:0] OP_JNZ      = 8'h32;
	localparam logic [7:0] OP_JEQ      = 8'h33;
	localparam logic [7:0] OP_READ     = 8'h40;
	localparam logic [7:0] OP_WRITE    = 8'h41;
	localparam logic [7:0] OP_CALL     = 8'h50;
	localparam logic [7:0] OP_RET      = 8'h51;

	localparam logic [2:0] ERR_NONE    = 3'd0;
	localparam logic [2:0] ERR_OVERRUN = 3'd1;
	localparam logic [2:0] ERR_OVERFLOW = 3'd2;
	localparam logic [2:0] ERR_UNDERFLOW = 3'd3;
	localparam logic [2:0] ERR_MODZERO = 3'd4;
	localparam logic [2:0] ERR_BOUND   = 3'd5;
	localparam logic [2:0] ERR_BADOP   = 3'd6;

	localparam logic [7:0] RET_ADDR    = 8'hFF;
	localparam logic [0:0] REG_CODE_LENGTH = 1'b0;

	function automatic logic op_known(input logic [7:0] op);
		logic k;
		unique case (op)
			OP_HALT, OP_PUSH8, OP_PUSH16, OP_POP, OP_DUP, OP_SWAP,
			OP_ADD, OP_SUB, OP_MUL, OP_MOD, OP_XOR, OP_AND, OP_OR, OP_NOT,
			OP_ROL, OP_ROR, OP_LOAD, OP_STORE, OP_LDI, OP_JMP, OP_JZ,
			OP_JNZ, OP_JEQ, OP_READ, OP_WRITE, OP_CALL, OP_RET: k = 1'b1;
			default: k = 1'b0;
		endcase
		return k;
	endfunction

	function automatic logic [1:0] op_need(input logic [7:0] op);
		logic [1:0] n;
		unique case (op)
			OP_PUSH8: n = 2'd1;
			OP_PUSH16, OP_JMP, OP_JZ, OP_JNZ, OP_JEQ, OP_CALL: n = 2'd2;
			default: n = 2'd0;
		endcase
		return n;
	endfunction

	function automatic logic [1:0] op_pops(input logic [7:0] op);
		logic [1:0] p;
		unique case (op)
			OP_POP, OP_NOT, OP_LOAD, OP_LDI, OP_JZ, OP_JNZ,
			OP_WRITE, OP_RET: p = 2'd1;
			OP_HALT, OP_PUSH8, OP_PUSH16, OP_DUP, OP_SWAP, OP_JMP,
			OP_READ, OP_CALL: p = 2'd0;
			default: p = 2'd2;
		endcase
		return p;
	endfunction

	function automatic logic [1:0] op_min(input logic [7:0] op);
		logic [1:0] m;
		unique case (op)
			OP_DUP: m = 2'd1;
			OP_SWAP: m = 2'd2;
			default: m = op_pops(op);
		endcase
		return m;
	endfunction

	function automatic logic op_push(input logic [7:0] op);
		logic p;
		unique case (op)
			OP_PUSH8, OP_PUSH16, OP_DUP, OP_ADD, OP_SUB, OP_MUL, OP_MOD,
			OP_XOR, OP_AND, OP_OR, OP_NOT, OP_ROL, OP_ROR, OP_LOAD,
			OP_LDI, OP_READ, OP_CALL: p = 1'b1;
			default: p = 1'b0;
		endcase
		return p;
	endfunction

endpackage
`default_nettype wire

// File: hdl/sbm_ram.sv
`default_nettype none
module sbm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 512
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// File: hdl/sbm_mod_div.sv
`default_nettype none
module sbm_mod_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [15:0] dividend,
	input  wire logic [15:0] divisor,
	output logic             done,
	output logic [15:0]      remainder
);
	logic [15:0] rem_q;
	logic [15:0] quo_q;
	logic [15:0] div_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [16:0] trial;
	logic [16:0] diff;

	assign trial = {rem_q, quo_q[15]};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd16;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[14:0], 1'b0};
			rem_q <= diff[16] ? trial[15:0] : diff[15:0];
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;
endmodule
`default_nettype wire

// File: hdl/stack_bytecode_machine_core.sv
// Stack bytecode machine core.
// Instruction channel (op_valid/op_ready): operation, immediate and in_byte
// of the instruction at the current pc. Result channel (res_valid/res_ready):
// next_pc, WRITE output, HALT report and error code, one result per
// transaction. code_length is written through the APB-style port at address 0.
// One instruction at a time passes through a sequencer around two
// synchronous RAMs (value stack, byte memory), each with a registered read.
// States per instruction: IDLE, RDB, EXEC, WB for most; LOAD and HALT add
// MEM1, LDI adds MEM1 and MEM2, SWAP adds SWAP and MOD waits in DIV for the
// 16-step remainder unit; once stopped or on a decode error IDLE goes to WB.
// The next instruction is accepted in the cycle its predecessor's result
// becomes valid, while that result may still be held by the receiver.
// Reset: a clearing pass zeroes each byte memory address in turn, with
// op_ready low throughout; configuration writes are taken meanwhile.
// A stalled receiver holds the result; the write-back of the next
// instruction waits until the held transaction is taken.
// After HALT or an error the core stops and answers every instruction with
// the unchanged pc until reset.
`default_nettype none
`include "stack_bytecode_machine_core_assert.svh"
module stack_bytecode_machine_core #(
	parameter int STACK_DEPTH = 512,
	parameter int MEM_DEPTH   = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        op_valid,
	output logic             op_ready,
	input  wire logic [7:0]  operation,
	input  wire logic [15:0] immediate,
	input  wire logic [7:0]  in_byte,
	output logic             res_valid,
	input  wire logic        res_ready,
	output logic [15:0]      next_pc,
	output logic             out_valid,
	output logic [7:0]       out_byte,
	output logic             halted,
	output logic [7:0]       return_byte,
	output logic             passed,
	output logic [2:0]       error_code
);
	import sbm_pkg::*;

	localparam int SA_W = $clog2(STACK_DEPTH);
	localparam int SC_W = $clog2(STACK_DEPTH + 1);
	localparam int MA_W = $clog2(MEM_DEPTH);
	localparam logic [MA_W-1:0] CLR_LAST = MA_W'(MEM_DEPTH - 1);

	typedef enum logic [8:0] {
		S_CLEAR = 9'b000000001,
		S_IDLE  = 9'b000000010,
		S_RDB   = 9'b000000100,
		S_EXEC  = 9'b000001000,
		S_MEM1  = 9'b000010000,
		S_MEM2  = 9'b000100000,
		S_DIV   = 9'b001000000,
		S_SWAP  = 9'b010000000,
		S_WB    = 9'b100000000
	} state_t;

	state_t          state_q;
	logic [MA_W-1:0] clr_q;
	logic [SC_W-1:0] sc_q;
	logic [15:0]     pc_q;
	logic            stopped_q;
	logic            res_valid_q;
	logic [15:0]     code_length_q;

	logic [7:0]      op_q;
	logic [15:0]     imm_q;
	logic [7:0]      inb_q;
	logic [15:0]     a_q;
	logic [15:0]     b_q;
	logic [15:0]     r_q;
	logic [7:0]      rb_q;
	logic [15:0]     npc_q;
	logic [SC_W-1:0] scp_q;
	logic [2:0]      err_q;

	logic [15:0]     next_pc_q;
	logic            out_valid_q;
	logic [7:0]      out_byte_q;
	logic            halted_q;
	logic [7:0]      return_byte_q;
	logic            passed_q;
	logic [2:0]      error_code_q;

	logic            cfg_wr;
	logic [2:0]      pre_err;
	logic [16:0]     pc_end;
	logic [15:0]     a_w;
	logic [15:0]     alu_r;
	logic [15:0]     seq_npc;
	logic [15:0]     exec_npc;
	logic [2:0]      exec_err;
	logic [SC_W-1:0] sc_pop;
	logic            b_bound;
	logic [15:0]     prod;
	logic [2:0]      rot;
	logic [23:0]     bw;
	logic [23:0]     rol_w;
	logic [23:0]     ror_w;
	logic            push_w;
	logic            ovf;
	logic [2:0]      wb_err;
	logic            wb_go;
	logic            commit;

	logic            stk_we;
	logic [SA_W-1:0] stk_waddr;
	logic [15:0]     stk_wdata;
	logic [SA_W-1:0] stk_raddr;
	logic [15:0]     stk_rdata;
	logic            dm_we;
	logic [MA_W-1:0] dm_waddr;
	logic [7:0]      dm_wdata;
	logic [MA_W-1:0] dm_raddr;
	logic [7:0]      dm_rdata;
	logic            div_start;
	logic            div_done;
	logic [15:0]     div_rem;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CODE_LENGTH);
	assign prdata = (paddr[2] == REG_CODE_LENGTH) ? {16'd0, code_length_q} : 32'd0;

	assign op_ready  = (state_q == S_IDLE);
	assign res_valid = res_valid_q;

	assign pc_end = {1'b0, pc_q} + 17'(op_need(operation));

	always_comb begin
		priority if (pc_q >= code_length_q) pre_err = ERR_OVERRUN;
		else if (!op_known(operation)) pre_err = ERR_BADOP;
		else if ((op_need(operation) != 2'd0) && (pc_end >= {1'b0, code_length_q}))
			pre_err = ERR_OVERRUN;
		else if (sc_q < SC_W'(op_min(operation))) pre_err = ERR_UNDERFLOW;
		else pre_err = ERR_NONE;
	end

	assign a_w     = stk_rdata;
	assign sc_pop  = sc_q - SC_W'(op_pops(op_q));
	assign b_bound = ({1'b0, b_q} >= 17'(MEM_DEPTH));
	assign seq_npc = pc_q + 16'd1 + 16'(op_need(op_q));
	assign prod    = 16'(a_w[7:0] * b_q[7:0]);
	assign rot     = a_w[2:0];
	assign bw      = {8'd0, b_q};
	assign rol_w   = (bw << rot) | (bw >> (4'd8 - {1'b0, rot}));
	assign ror_w   = (bw >> rot) | (bw << (4'd8 - {1'b0, rot}));

	always_comb begin
		unique case (op_q)
			OP_PUSH8:  alu_r = {8'd0, imm_q[7:0]};
			OP_PUSH16: alu_r = imm_q;
			OP_DUP:    alu_r = b_q;
			OP_ADD:    alu_r = {8'd0, 8'(a_w[7:0] + b_q[7:0])};
			OP_SUB:    alu_r = {8'd0, 8'(a_w[7:0] - b_q[7:0])};
			OP_MUL:    alu_r = {8'd0, prod[7:0]};
			OP_XOR:    alu_r = a_w ^ b_q;
			OP_AND:    alu_r = a_w & b_q;
			OP_OR:     alu_r = a_w | b_q;
			OP_NOT:    alu_r = {8'd0, ~b_q[7:0]};
			OP_ROL:    alu_r = {8'd0, rol_w[7:0]};
			OP_ROR:    alu_r = {8'd0, ror_w[7:0]};
			OP_READ:   alu_r = {8'd0, inb_q};
			OP_CALL:   alu_r = seq_npc;
			default:   alu_r = 16'd0;
		endcase
	end

	always_comb begin
		unique case (op_q)
			OP_JMP, OP_CALL: exec_npc = imm_q;
			OP_JZ:   exec_npc = (b_q == 16'd0) ? imm_q : seq_npc;
			OP_JNZ:  exec_npc = (b_q != 16'd0) ? imm_q : seq_npc;
			OP_JEQ:  exec_npc = (a_w == b_q) ? imm_q : seq_npc;
			OP_RET:  exec_npc = b_q;
			default: exec_npc = seq_npc;
		endcase
	end

	always_comb begin
		unique case (op_q)
			OP_MOD: exec_err = (b_q == 16'd0) ? ERR_MODZERO : ERR_NONE;
			OP_LOAD, OP_STORE, OP_LDI: exec_err = b_bound ? ERR_BOUND : ERR_NONE;
			default: exec_err = ERR_NONE;
		endcase
	end

	assign push_w = op_push(op_q);
	assign ovf    = push_w && (scp_q >= SC_W'(STACK_DEPTH));
	assign wb_err = (err_q != ERR_NONE) ? err_q : (ovf ? ERR_OVERFLOW : ERR_NONE);
	assign wb_go  = (state_q == S_WB) && (!res_valid_q || res_ready);
	assign commit = wb_go && !stopped_q && (wb_err == ERR_NONE);

	assign div_start = (state_q == S_EXEC) && (op_q == OP_MOD) && (exec_err == ERR_NONE);

	always_comb begin
		stk_raddr = (state_q == S_IDLE) ? SA_W'(sc_q - SC_W'(1)) : SA_W'(sc_q - SC_W'(2));
		stk_we    = (state_q == S_SWAP) || (commit && (push_w || (op_q == OP_SWAP)));
		if (state_q == S_SWAP) begin
			stk_waddr = SA_W'(sc_q - SC_W'(2));
			stk_wdata = b_q;
		end else if (op_q == OP_SWAP) begin
			stk_waddr = SA_W'(sc_q - SC_W'(1));
			stk_wdata = a_q;
		end else begin
			stk_waddr = SA_W'(scp_q);
			stk_wdata = r_q;
		end
	end

	always_comb begin
		dm_we    = (state_q == S_CLEAR) || (commit && (op_q == OP_STORE));
		dm_waddr = (state_q == S_CLEAR) ? clr_q : b_q[MA_W-1:0];
		dm_wdata = (state_q == S_CLEAR) ? 8'd0 : a_q[7:0];
		if (state_q == S_MEM1) dm_raddr = MA_W'(dm_rdata);
		else if (op_q == OP_HALT) dm_raddr = MA_W'(RET_ADDR);
		else dm_raddr = b_q[MA_W-1:0];
	end

	sbm_ram #(.WIDTH(16), .DEPTH(STACK_DEPTH)) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	sbm_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_data (
		.clk   (clk),
		.we    (dm_we),
		.waddr (dm_waddr),
		.wdata (dm_wdata),
		.raddr (dm_raddr),
		.rdata (dm_rdata)
	);

	sbm_mod_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (a_w),
		.divisor   (b_q),
		.done      (div_done),
		.remainder (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			clr_q         <= '0;
			sc_q          <= '0;
			pc_q          <= '0;
			stopped_q     <= 1'b0;
			res_valid_q   <= 1'b0;
			code_length_q <= 16'd1;
		end else begin
			if (cfg_wr) code_length_q <= pwdata[15:0];
			if (wb_go) res_valid_q <= 1'b1;
			else if (res_ready) res_valid_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + MA_W'(1);
					if (clr_q == CLR_LAST) state_q <= S_IDLE;
				end
				S_IDLE: if (op_valid) begin
					if (stopped_q || (pre_err != ERR_NONE)) state_q <= S_WB;
					else state_q <= S_RDB;
				end
				S_RDB: state_q <= S_EXEC;
				S_EXEC: begin
					if (exec_err != ERR_NONE) state_q <= S_WB;
					else begin
						unique case (op_q)
							OP_MOD: state_q <= S_DIV;
							OP_LOAD, OP_LDI, OP_HALT: state_q <= S_MEM1;
							OP_SWAP: state_q <= S_SWAP;
							default: state_q <= S_WB;
						endcase
					end
				end
				S_MEM1: state_q <= (op_q == OP_LDI) ? S_MEM2 : S_WB;
				S_MEM2: state_q <= S_WB;
				S_DIV: if (div_done) state_q <= S_WB;
				S_SWAP: state_q <= S_WB;
				S_WB: if (wb_go) begin
					state_q <= S_IDLE;
					if (commit) begin
						sc_q <= scp_q + SC_W'(push_w);
						pc_q <= npc_q;
						if (op_q == OP_HALT) stopped_q <= 1'b1;
					end else begin
						stopped_q <= 1'b1;
					end
				end
				default: state_q <= S_CLEAR;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: if (op_valid) begin
				op_q  <= operation;
				imm_q <= immediate;
				inb_q <= in_byte;
				err_q <= pre_err;
			end
			S_RDB: b_q <= stk_rdata;
			S_EXEC: begin
				a_q   <= a_w;
				r_q   <= alu_r;
				npc_q <= exec_npc;
				scp_q <= sc_pop;
				err_q <= exec_err;
			end
			S_MEM1: begin
				rb_q <= dm_rdata;
				r_q  <= {8'd0, dm_rdata};
			end
			S_MEM2: r_q <= {8'd0, dm_rdata};
			S_DIV: if (div_done) r_q <= div_rem;
			S_WB: if (wb_go) begin
				out_valid_q   <= 1'b0;
				out_byte_q    <= 8'd0;
				halted_q      <= 1'b0;
				return_byte_q <= 8'd0;
				passed_q      <= 1'b0;
				error_code_q  <= ERR_NONE;
				next_pc_q     <= pc_q;
				if (!stopped_q) begin
					if (wb_err != ERR_NONE) begin
						error_code_q <= wb_err;
					end else begin
						next_pc_q <= npc_q;
						if (op_q == OP_WRITE) begin
							out_valid_q <= 1'b1;
							out_byte_q  <= b_q[7:0];
						end
						if (op_q == OP_HALT) begin
							halted_q      <= 1'b1;
							return_byte_q <= rb_q;
							passed_q      <= (rb_q == 8'd0);
						end
					end
				end
			end
			default: ;
		endcase
	end

	assign next_pc     = next_pc_q;
	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign halted      = halted_q;
	assign return_byte = return_byte_q;
	assign passed      = passed_q;
	assign error_code  = error_code_q;

	`SBM_ASSERT_NEXT(a_stop_holds, clk, arst_n, stopped_q, stopped_q)
	`SBM_ASSERT_IMP(a_state_onehot, clk, arst_n, 1'b1, $onehot(state_q))
	`SBM_ASSERT_IMP(a_err_excl, clk, arst_n, res_valid_q && (error_code_q != ERR_NONE), !halted_q && !out_valid_q)
	`SBM_ASSERT_IMP(a_sc_bound, clk, arst_n, 1'b1, sc_q <= SC_W'(STACK_DEPTH))
endmodule
`default_nettype wire

// File: tb/sv/tb.sv
`default_nettype none
module tb;
	import sbm_pkg::*;

	localparam int STK_ENTRIES = 512;
	localparam int MEM_ENTRIES = 1024;

	typedef struct packed {
		logic [7:0]  operation;
		logic [15:0] immediate;
		logic [7:0]  in_byte;
	} instr_t;

	typedef struct packed {
		logic [15:0] next_pc;
		logic        out_valid;
		logic [7:0]  out_byte;
		logic        halted;
		logic [7:0]  return_byte;
		logic        passed;
		logic [2:0]  error_code;
	} result_t;

	class bytecode_tracker;
		logic [15:0] stack_mem [STK_ENTRIES];
		logic [7:0]  byte_mem [MEM_ENTRIES];
		int unsigned depth;
		int unsigned pc_reg;
		bit          frozen;
		int unsigned code_len;
		result_t     expected_results [$];
		int          mismatches;

		function new();
			foreach (stack_mem[i]) stack_mem[i] = '0;
			foreach (byte_mem[i]) byte_mem[i] = '0;
			depth = 0;
			pc_reg = 0;
			frozen = 0;
			code_len = 1;
			mismatches = 0;
		endfunction

		function result_t execute(instr_t it, bit commit);
			result_t r;
			int unsigned pc, sc, npc, need, a, b, v, c, p, mem_addr;
			int unsigned pops;
			bit known, push, do_swap, do_store;
			logic [2:0] err;
			logic [15:0] swap_top;
			r = '0;
			pc = pc_reg;
			sc = depth;
			a = 0;
			b = 0;
			v = 0;
			need = 0;
			known = 1;
			push = 0;
			do_swap = 0;
			do_store = 0;
			mem_addr = 0;
			pops = 0;
			err = ERR_NONE;
			if (frozen) begin
				r.next_pc = pc[15:0];
				return r;
			end
			case (it.operation)
				OP_PUSH8: need = 1;
				OP_PUSH16, OP_JMP, OP_JZ, OP_JNZ, OP_JEQ, OP_CALL: need = 2;
				OP_HALT, OP_POP, OP_DUP, OP_SWAP, OP_READ, OP_WRITE, OP_RET,
				OP_LOAD, OP_STORE, OP_LDI, OP_ADD, OP_SUB, OP_MUL, OP_MOD,
				OP_XOR, OP_AND, OP_OR, OP_NOT, OP_ROL, OP_ROR: need = 0;
				default: known = 0;
			endcase
			npc = pc + 1;
			if (pc >= code_len) err = ERR_OVERRUN;
			else if (!known) err = ERR_BADOP;
			else if (need != 0 && pc + need >= code_len) err = ERR_OVERRUN;
			if (err == ERR_NONE) begin
				npc = pc + 1 + need;
				case (it.operation)
					OP_POP, OP_NOT, OP_LOAD, OP_LDI, OP_JZ, OP_JNZ, OP_WRITE,
					OP_RET: pops = 1;
					OP_HALT, OP_PUSH8, OP_PUSH16, OP_DUP, OP_SWAP, OP_JMP, OP_READ,
					OP_CALL: pops = 0;
					default: pops = 2;
				endcase
				if (it.operation == OP_DUP && sc < 1) err = ERR_UNDERFLOW;
				else if (it.operation == OP_SWAP && sc < 2) err = ERR_UNDERFLOW;
				else if (sc < pops) err = ERR_UNDERFLOW;
			end
			if (err == ERR_NONE) begin
				if (pops >= 1) b = stack_mem[sc - 1];
				if (pops >= 2) a = stack_mem[sc - 2];
				sc = sc - pops;
				case (it.operation)
					OP_HALT: begin
						r.halted = 1;
						r.return_byte = byte_mem[255];
						r.passed = (byte_mem[255] == 0);
					end
					OP_PUSH8: begin v = it.immediate[7:0]; push = 1; end
					OP_PUSH16: begin v = it.immediate; push = 1; end
					OP_DUP: begin v = stack_mem[sc - 1]; push = 1; end
					OP_SWAP: do_swap = 1;
					OP_ADD: begin v = (a + b) & 32'hFF; push = 1; end
					OP_SUB: begin v = (a - b) & 32'hFF; push = 1; end
					OP_MUL: begin v = (a * b) & 32'hFF; push = 1; end
					OP_MOD: begin
						if (b == 0) err = ERR_MODZERO;
						else begin v = a % b; push = 1; end
					end
					OP_XOR: begin v = a ^ b; push = 1; end
					OP_AND: begin v = a & b; push = 1; end
					OP_OR: begin v = a | b; push = 1; end
					OP_NOT: begin v = (~b) & 32'hFF; push = 1; end
					OP_ROL: begin
						c = a & 7;
						v = ((b << c) | (b >> (8 - c))) & 32'hFF;
						push = 1;
					end
					OP_ROR: begin
						c = a & 7;
						v = ((b >> c) | (b << (8 - c))) & 32'hFF;
						push = 1;
					end
					OP_LOAD: begin
						if (b >= MEM_ENTRIES) err = ERR_BOUND;
						else begin v = byte_mem[b]; push = 1; end
					end
					OP_STORE: begin
						if (b >= MEM_ENTRIES) err = ERR_BOUND;
						else begin do_store = 1; mem_addr = b; end
					end
					OP_LDI: begin
						if (b >= MEM_ENTRIES) err = ERR_BOUND;
						else begin
							p = byte_mem[b];
							if (p >= MEM_ENTRIES) err = ERR_BOUND;
							else begin v = byte_mem[p]; push = 1; end
						end
					end
					OP_JMP: npc = it.immediate;
					OP_JZ: if (b == 0) npc = it.immediate;
					OP_JNZ: if (b != 0) npc = it.immediate;
					OP_JEQ: if (a == b) npc = it.immediate;
					OP_READ: begin v = it.in_byte; push = 1; end
					OP_WRITE: begin r.out_valid = 1; r.out_byte = b[7:0]; end
					OP_CALL: begin v = npc; push = 1; npc = it.immediate; end
					OP_RET: npc = b;
					default: ;
				endcase
				if (err == ERR_NONE && push && sc >= STK_ENTRIES) err = ERR_OVERFLOW;
			end
			if (err != ERR_NONE) begin
				if (commit) frozen = 1;
				r = '0;
				r.next_pc = pc[15:0];
				r.error_code = err;
				return r;
			end
			if (commit) begin
				if (do_swap) begin
					swap_top = stack_mem[sc - 1];
					stack_mem[sc - 1] = stack_mem[sc - 2];
					stack_mem[sc - 2] = swap_top;
				end
				if (do_store) byte_mem[mem_addr] = a[7:0];
				if (push) begin
					stack_mem[sc] = v[15:0];
					sc = sc + 1;
				end
				depth = sc;
				pc_reg = npc & 32'hFFFF;
				if (r.halted) frozen = 1;
			end
			r.next_pc = npc[15:0];
			return r;
		endfunction

		function void note_instr(instr_t it);
			expected_results.push_back(execute(it, 1));
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			mismatches++;
		endtask

		task check_result(result_t got);
			result_t want;
			if (expected_results.size() == 0) begin
				report($sformatf("unexpected result pc %h", got.next_pc));
				return;
			end
			want = expected_results.pop_front();
			if (got.next_pc !== want.next_pc)
				report($sformatf("next_pc %h want %h", got.next_pc, want.next_pc));
			if (got.out_valid !== want.out_valid)
				report($sformatf("out_valid %b want %b", got.out_valid, want.out_valid));
			if (got.out_byte !== want.out_byte)
				report($sformatf("out_byte %h want %h", got.out_byte, want.out_byte));
			if (got.halted !== want.halted)
				report($sformatf("halted %b want %b", got.halted, want.halted));
			if (got.return_byte !== want.return_byte)
				report($sformatf("return_byte %h want %h", got.return_byte, want.return_byte));
			if (got.passed !== want.passed)
				report($sformatf("passed %b want %b", got.passed, want.passed));
			if (got.error_code !== want.error_code)
				report($sformatf("error_code %0d want %0d", got.error_code, want.error_code));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        op_valid, op_ready;
	logic [7:0]  operation;
	logic [15:0] immediate;
	logic [7:0]  in_byte;
	logic        res_valid, res_ready;
	logic [15:0] next_pc;
	logic        out_valid;
	logic [7:0]  out_byte;
	logic        halted;
	logic [7:0]  return_byte;
	logic        passed;
	logic [2:0]  error_code;

	int tx_idle_pct;
	int rx_idle_pct;
	int hold_request;
	int hold_left;
	bytecode_tracker tracker;

	stack_bytecode_machine_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.op_valid(op_valid), .op_ready(op_ready), .operation(operation),
		.immediate(immediate), .in_byte(in_byte),
		.res_valid(res_valid), .res_ready(res_ready), .next_pc(next_pc),
		.out_valid(out_valid), .out_byte(out_byte), .halted(halted),
		.return_byte(return_byte), .passed(passed), .error_code(error_code)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("tb failed");
		$finish;
	end

	initial begin
		res_ready = 0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_request != 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				res_ready = 0;
				hold_left--;
			end else begin
				res_ready = ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready)
			tracker.check_result('{next_pc, out_valid, out_byte, halted,
				return_byte, passed, error_code});
	end

	task automatic write_code_length(int unsigned value);
		@(negedge clk);
		psel = 1;
		penable = 0;
		pwrite = 1;
		paddr = {REG_CODE_LENGTH, 2'b00};
		pwdata = value;
		@(negedge clk);
		penable = 1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		tracker.code_len = value & 32'hFFFF;
		@(negedge clk);
		psel = 0;
		penable = 0;
		pwrite = 0;
	endtask

	task automatic send_instr(instr_t it);
		operation = it.operation;
		immediate = it.immediate;
		in_byte = it.in_byte;
		op_valid = 1;
		do @(posedge clk); while (!op_ready);
		tracker.note_instr(it);
		@(negedge clk);
		if ($urandom_range(99) < tx_idle_pct) begin
			op_valid = 0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
	endtask

	task automatic drain();
		op_valid = 0;
		while (tracker.expected_results.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic bit stays_runnable(instr_t it);
		result_t r;
		r = tracker.execute(it, 0);
		return r.error_code == ERR_NONE && !r.halted && r.next_pc + 2 < tracker.code_len;
	endfunction

	function automatic logic [7:0] pick_op();
		case ($urandom_range(29))
			0, 1, 2: return OP_PUSH8;
			3, 4, 5: return OP_PUSH16;
			6: return OP_READ;
			7, 8: return OP_DUP;
			9: return OP_SWAP;
			10: return OP_POP;
			11: return OP_ADD;
			12: return OP_SUB;
			13: return OP_MUL;
			14: return OP_MOD;
			15: return OP_XOR;
			16: return OP_AND;
			17: return OP_OR;
			18: return OP_NOT;
			19: return OP_ROL;
			20: return OP_ROR;
			21: return OP_LOAD;
			22: return OP_STORE;
			23: return OP_LDI;
			24: return OP_JMP;
			25: return OP_JZ;
			26: return OP_JNZ;
			27: return OP_JEQ;
			28: return OP_WRITE;
			default: return ($urandom_range(1)) ? OP_CALL : OP_RET;
		endcase
	endfunction

	function automatic instr_t random_instr();
		instr_t it;
		it.operation = pick_op();
		it.immediate = $urandom;
		it.in_byte = ($urandom_range(7) == 0) ? 8'hFF : 8'($urandom);
		case (it.operation)
			OP_JMP, OP_JZ, OP_JNZ, OP_JEQ, OP_CALL:
				if ($urandom_range(9) < 8)
					it.immediate = $urandom_range(tracker.code_len - 3, 0);
			OP_PUSH16:
				if ($urandom_range(1)) it.immediate = $urandom_range(MEM_ENTRIES - 1, 0);
			default: ;
		endcase
		return it;
	endfunction

	task automatic run_random(int count);
		instr_t it;
		bit found;
		repeat (count) begin
			found = 0;
			for (int t = 0; t < 50 && !found; t++) begin
				it = random_instr();
				found = stays_runnable(it);
			end
			if (!found)
				it = '{OP_JMP, 16'($urandom_range(tracker.code_len - 3, 0)), 8'($urandom)};
			send_instr(it);
		end
	endtask

	task automatic run_directed();
		instr_t seq [$];
		seq = '{
			'{OP_PUSH16, 16'hFFFF, 8'h00}, '{OP_PUSH8, 16'hFF80, 8'h00},
			'{OP_DUP, 16'h0000, 8'h00}, '{OP_SWAP, 16'h0000, 8'h00},
			'{OP_ADD, 16'h0000, 8'h00}, '{OP_READ, 16'h0000, 8'hFF},
			'{OP_WRITE, 16'h0000, 8'h00}, '{OP_PUSH8, 16'h002A, 8'h00},
			'{OP_PUSH16, 16'h00FF, 8'h00}, '{OP_STORE, 16'h0000, 8'h00},
			'{OP_PUSH16, 16'h00FF, 8'h00}, '{OP_LDI, 16'h0000, 8'h00},
			'{OP_PUSH8, 16'h0003, 8'h00}, '{OP_ROL, 16'h0000, 8'h00},
			'{OP_PUSH8, 16'h0005, 8'h00}, '{OP_ROR, 16'h0000, 8'h00},
			'{OP_PUSH16, 16'h00FF, 8'h00}, '{OP_LOAD, 16'h0000, 8'h00},
			'{OP_MOD, 16'h0000, 8'h00}, '{OP_READ, 16'h0000, 8'h00},
			'{OP_MUL, 16'h0000, 8'h00}, '{OP_NOT, 16'h0000, 8'h00},
			'{OP_READ, 16'h0000, 8'h7F}, '{OP_XOR, 16'h0000, 8'h00},
			'{OP_READ, 16'h0000, 8'h81}, '{OP_SUB, 16'h0000, 8'h00},
			'{OP_DUP, 16'h0000, 8'h00}, '{OP_AND, 16'h0000, 8'h00},
			'{OP_DUP, 16'h0000, 8'h00}, '{OP_OR, 16'h0000, 8'h00},
			'{OP_DUP, 16'h0000, 8'h00}, '{OP_JEQ, 16'h0000, 8'h00},
			'{OP_JZ, 16'h0040, 8'h00}, '{OP_CALL, 16'h0100, 8'h00},
			'{OP_RET, 16'h0000, 8'h00}, '{OP_PUSH8, 16'h0001, 8'h00},
			'{OP_JNZ, 16'h0020, 8'h00}, '{OP_POP, 16'h0000, 8'h00},
			'{OP_JMP, 16'h0000, 8'h00}
		};
		foreach (seq[i])
			if (stays_runnable(seq[i])) send_instr(seq[i]);
	endtask

	task automatic run_final();
		instr_t it;
		result_t chk;
		bit found;
		case ($urandom_range(2))
			0: send_instr('{OP_HALT, 16'($urandom), 8'($urandom)});
			1: begin
				drain();
				write_code_length(1);
				send_instr('{OP_PUSH16, 16'($urandom), 8'($urandom)});
			end
			default: begin
				found = 0;
				for (int t = 0; t < 2000 && !found; t++) begin
					it = '{8'($urandom), 16'($urandom), 8'($urandom)};
					chk = tracker.execute(it, 0);
					found = (chk.error_code != ERR_NONE);
				end
				if (!found) it = '{8'hFF, 16'h0000, 8'h00};
				send_instr(it);
			end
		endcase
		repeat (8) send_instr('{8'($urandom), 16'($urandom), 8'($urandom)});
	endtask

	initial begin
		tracker = new();
		tx_idle_pct = 34;
		rx_idle_pct = 77;
		hold_request = 0;
		arst_n = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = '0;
		pwdata = '0;
		op_valid = 0;
		operation = '0;
		immediate = '0;
		in_byte = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		write_code_length(65535);
		run_directed();
		run_random(400);
		send_instr('{OP_JMP, 16'h0000, 8'h00});
		drain();

		write_code_length($urandom_range(40, 3));
		tx_idle_pct = 77;
		rx_idle_pct = 34;
		hold_request = 400;
		run_random(400);
		send_instr('{OP_JMP, 16'h0000, 8'h00});
		drain();

		write_code_length($urandom_range(65534, 41));
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		run_random(200);
		op_valid = 0;
		drain();
		run_random(200);
		run_final();
		drain();
		if (tracker.mismatches == 0 && tracker.expected_results.size() == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end
endmodule
`default_nettype wire
